FILE: rtl/tsf_pkg.sv
// Shared constants, tag tables and types for the think-tag stream filter.
`timescale 1ns / 1ps

package tsf_pkg;

   localparam int TAIL_DEPTH = 8;
   localparam int OPEN_LEN   = 7;
   localparam int CLOSE_LEN  = 8;
   localparam int CNT_W      = $clog2(TAIL_DEPTH + 1);
   localparam int POS_W      = $clog2(TAIL_DEPTH);

   // "<think>" and "</think>", first character at index 0
   localparam logic [7:0] OPEN_TAG [OPEN_LEN] = '{
      8'h3C, 8'h74, 8'h68, 8'h69, 8'h6E, 8'h6B, 8'h3E
   };
   localparam logic [7:0] CLOSE_TAG [CLOSE_LEN] = '{
      8'h3C, 8'h2F, 8'h74, 8'h68, 8'h69, 8'h6E, 8'h6B, 8'h3E
   };

   // cells that take part in each window compare
   localparam logic [TAIL_DEPTH-1:0] OPEN_A_MASK = 8'b0011_1111;
   localparam logic [TAIL_DEPTH-1:0] OPEN_B_MASK = 8'b0111_1111;
   localparam logic [TAIL_DEPTH-1:0] OPEN_C_MASK = 8'b1111_1110;
   localparam logic [TAIL_DEPTH-1:0] CLOSE_MASK  = 8'b0111_1111;

   localparam logic CMD_DATA   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // per-cell compare flags
   typedef struct packed {
      logic open_a;   // new byte closes an open tag
      logic open_b;   // open tag ends at the newest held byte
      logic open_c;   // open tag ends one byte before the newest
      logic close;    // new byte closes a close tag
   } tsf_match_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       turn_end;
   } tsf_result_type;

   function automatic logic [7:0] open_char(input int idx);
      if (idx >= 0 && idx < OPEN_LEN) return OPEN_TAG[idx[2:0]];
      return 8'h00;
   endfunction

   function automatic logic [7:0] close_char(input int idx);
      if (idx >= 0 && idx < CLOSE_LEN) return CLOSE_TAG[idx[2:0]];
      return 8'h00;
   endfunction

endpackage

FILE: rtl/think_tag_stream_filter.sv
// Top level of the think-tag stream filter.
`timescale 1ns / 1ps

// Removes every span from "<think>" through "</think>" out of a byte stream.
// A data transfer (req_tuser = 0) yields at most one byte, so text streams at
// one byte per clock while the output is not stalled and no flush runs; bytes
// lag the input by up to seven positions because an eight-cell tail chain
// holds them back until no tag can still be forming. A finish transfer
// (req_tuser = 1) flushes the tail and clears the state, the flush reading one
// tail cell per cycle into the output register while the output takes them,
// and always ends with a transfer that has rsp_tlast set; when nothing is left
// to flush that transfer carries no byte (rsp_tuser = 0, rsp_tdata = 0). If no
// byte left during the turn, the flush drops a complete open tag from the tail
// and emits the rest even inside a span. req_tdata is ignored on a finish.

module think_tag_stream_filter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] byte_valid
   output logic       rsp_tlast
);

   logic                    push_valid;
   logic                    push_ready;
   tsf_pkg::tsf_result_type push_data;
   tsf_pkg::tsf_result_type out_data;

   tsf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_command (req_tuser),
      .in_byte    (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tsf_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_data)
   );

   assign rsp_tdata = out_data.out_byte;
   assign rsp_tuser = out_data.byte_valid;
   assign rsp_tlast = out_data.turn_end;

endmodule

FILE: rtl/tsf_cell.sv
// One tail cell: holds a byte, passes it on when the chain shifts, compares it with tag characters.
`timescale 1ns / 1ps

module tsf_cell (
   input  logic                   clock,
   input  logic                   shift_en,
   input  logic [7:0]             byte_in,
   input  logic [7:0]             ch_open_a,
   input  logic [7:0]             ch_open_b,
   input  logic [7:0]             ch_open_c,
   input  logic [7:0]             ch_close,
   output logic [7:0]             byte_out,
   output tsf_pkg::tsf_match_type match
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_sel;

   assign byte_in_sel = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_sel;
   end

   assign byte_out     = byte_ff;
   assign match.open_a = (byte_ff == ch_open_a);
   assign match.open_b = (byte_ff == ch_open_b);
   assign match.open_c = (byte_ff == ch_open_c);
   assign match.close  = (byte_ff == ch_close);

endmodule

FILE: rtl/tsf_core.sv
// Tail cell chain with span mode, emit decision and finish flush sequencing.
`timescale 1ns / 1ps

module tsf_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic                    in_command,
   input  logic [7:0]              in_byte,
   output logic                    push_valid,
   input  logic                    push_ready,
   output tsf_pkg::tsf_result_type push_data
);

   localparam int DEPTH = tsf_pkg::TAIL_DEPTH;
   localparam int CW    = tsf_pkg::CNT_W;
   localparam int PW    = tsf_pkg::POS_W;

   // cell k holds the byte received k transfers before the newest one
   logic [7:0]             cell_byte [DEPTH];
   tsf_pkg::tsf_match_type cell_match [DEPTH];
   logic [DEPTH-1:0]       vec_a, vec_b, vec_c, vec_d;
   logic                   shift_en;

   genvar k;
   generate
      for (k = 0; k < DEPTH; k++) begin : g_cell
         tsf_cell u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .byte_in   ((k == 0) ? in_byte : cell_byte[(k == 0) ? 0 : k - 1]),
            .ch_open_a (tsf_pkg::open_char(tsf_pkg::OPEN_LEN - 2 - k)),
            .ch_open_b (tsf_pkg::open_char(tsf_pkg::OPEN_LEN - 1 - k)),
            .ch_open_c (tsf_pkg::open_char(tsf_pkg::OPEN_LEN - k)),
            .ch_close  (tsf_pkg::close_char(tsf_pkg::CLOSE_LEN - 2 - k)),
            .byte_out  (cell_byte[k]),
            .match     (cell_match[k])
         );
         assign vec_a[k] = cell_match[k].open_a;
         assign vec_b[k] = cell_match[k].open_b;
         assign vec_c[k] = cell_match[k].open_c;
         assign vec_d[k] = cell_match[k].close;
      end
   endgenerate

   logic          inside_ff, inside_in;
   logic          emitted_ff, emitted_in;
   logic [CW-1:0] count_ff, count_in;
   logic          flushing_ff, flushing_in;
   logic [PW-1:0] fpos_ff, fpos_in;
   logic [CW-1:0] fleft_ff, fleft_in;

   logic          accept, is_data, is_finish;
   logic          a_hit, b_hit, c_hit, d_hit;
   logic          open_hit, close_hit, data_emit;
   logic [PW-1:0] tail_top;
   logic [PW-1:0] fl_pos;
   logic [CW-1:0] fl_len;

   assign in_ready  = push_ready & ~flushing_ff;
   assign accept    = in_valid & in_ready;
   assign is_data   = accept & (in_command == tsf_pkg::CMD_DATA);
   assign is_finish = accept & (in_command == tsf_pkg::CMD_FINISH);
   assign shift_en  = is_data;

   assign a_hit = &(vec_a | ~tsf_pkg::OPEN_A_MASK);
   assign b_hit = &(vec_b | ~tsf_pkg::OPEN_B_MASK);
   assign c_hit = &(vec_c | ~tsf_pkg::OPEN_C_MASK);
   assign d_hit = &(vec_d | ~tsf_pkg::CLOSE_MASK);

   // a tag can only complete on the byte just received
   assign open_hit  = ~inside_ff & (in_byte == tsf_pkg::OPEN_TAG[tsf_pkg::OPEN_LEN-1])
                      & (count_ff >= CW'(tsf_pkg::OPEN_LEN - 1)) & a_hit;
   assign close_hit = inside_ff & (in_byte == tsf_pkg::CLOSE_TAG[tsf_pkg::CLOSE_LEN-1])
                      & (count_ff >= CW'(tsf_pkg::CLOSE_LEN - 1)) & d_hit;
   // outside a span a full window pushes the oldest byte out, tag or not
   assign data_emit = ~inside_ff & (count_ff == CW'(tsf_pkg::OPEN_LEN));

   assign tail_top = count_ff[PW-1:0] - 1'b1;

   // flush range: fl_len bytes starting at the oldest, cell fl_pos
   always_comb begin
      fl_pos = tail_top;
      fl_len = count_ff;
      if (!emitted_ff && count_ff != '0) begin
         if (count_ff == CW'(DEPTH) && c_hit) begin
            fl_pos = '0;
            fl_len = CW'(1);
         end else if (count_ff >= CW'(tsf_pkg::OPEN_LEN) && b_hit) begin
            // drop the open tag, keep the byte in front of it if any
            fl_pos = PW'(DEPTH - 1);
            fl_len = (count_ff == CW'(DEPTH)) ? CW'(1) : '0;
         end
      end else if (inside_ff) begin
         fl_len = '0;
      end
   end

   always_comb begin
      push_valid = 1'b0;
      push_data  = '{out_byte: 8'h00, byte_valid: 1'b0, turn_end: 1'b1};
      if (flushing_ff) begin
         push_valid = 1'b1;
         push_data  = '{out_byte: cell_byte[fpos_ff], byte_valid: 1'b1,
                        turn_end: (fleft_ff == CW'(1))};
      end else if (is_data && data_emit) begin
         push_valid = 1'b1;
         push_data  = '{out_byte: cell_byte[tsf_pkg::OPEN_LEN-1], byte_valid: 1'b1,
                        turn_end: 1'b0};
      end else if (is_finish && fl_len == '0) begin
         push_valid = 1'b1;
      end
   end

   always_comb begin
      inside_in   = inside_ff;
      emitted_in  = emitted_ff;
      count_in    = count_ff;
      flushing_in = flushing_ff;
      fpos_in     = fpos_ff;
      fleft_in    = fleft_ff;
      if (is_data) begin
         emitted_in = emitted_ff | data_emit;
         if (inside_ff) begin
            if (close_hit) begin
               inside_in = 1'b0;
               count_in  = '0;
            end else if (count_ff != CW'(DEPTH)) begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (open_hit) begin
               inside_in = 1'b1;
               count_in  = '0;
            end else if (count_ff != CW'(tsf_pkg::OPEN_LEN)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
      if (is_finish) begin
         inside_in  = 1'b0;
         emitted_in = 1'b0;
         count_in   = '0;
         if (fl_len != '0) begin
            flushing_in = 1'b1;
            fpos_in     = fl_pos;
            fleft_in    = fl_len;
         end
      end
      if (flushing_ff && push_ready) begin
         fpos_in  = fpos_ff - 1'b1;
         fleft_in = fleft_ff - 1'b1;
         if (fleft_ff == CW'(1)) flushing_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff   <= 1'b0;
         emitted_ff  <= 1'b0;
         count_ff    <= '0;
         flushing_ff <= 1'b0;
         fpos_ff     <= '0;
         fleft_ff    <= '0;
      end else begin
         inside_ff   <= inside_in;
         emitted_ff  <= emitted_in;
         count_ff    <= count_in;
         flushing_ff <= flushing_in;
         fpos_ff     <= fpos_in;
         fleft_ff    <= fleft_in;
      end
   end

endmodule

FILE: rtl/tsf_skid.sv
// Two-entry output register with skid slot between the filter and the result channel.
`timescale 1ns / 1ps

module tsf_skid (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  tsf_pkg::tsf_result_type push_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output tsf_pkg::tsf_result_type out_data
);

   logic                    main_valid_ff, main_valid_in;
   logic                    spare_valid_ff, spare_valid_in;
   tsf_pkg::tsf_result_type main_ff, main_in;
   tsf_pkg::tsf_result_type spare_ff, spare_in;
   logic                    push, out_fire;

   assign push_ready = ~spare_valid_ff;
   assign push       = push_valid & push_ready;
   assign out_fire   = main_valid_ff & out_ready;

   always_comb begin
      main_valid_in  = main_valid_ff;
      spare_valid_in = spare_valid_ff;
      main_in        = main_ff;
      spare_in       = spare_ff;
      if (main_valid_ff && !out_fire) begin
         // output stalled: park a new transfer in the spare slot
         if (push) begin
            spare_valid_in = 1'b1;
            spare_in       = push_data;
         end
      end else if (spare_valid_ff) begin
         main_valid_in  = 1'b1;
         main_in        = spare_ff;
         spare_valid_in = 1'b0;
      end else begin
         main_valid_in = push;
         main_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff  <= main_in;
      spare_ff <= spare_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

FILE: rtl/tsf_checker.sv
// Port-level checks for the think-tag stream filter, bound to the top level.
`timescale 1ns / 1ps

module tsf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled result transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a result without a byte only closes a turn and carries zero
   a_empty_ends_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata == 8'h00)
      else $error("empty result outside a turn end");

   // a finish always leaves something valid at the output
   a_finish_output: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |-> ##[1:2] rsp_tvalid)
      else $error("finish transfer produced no result");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind think_tag_stream_filter tsf_checker u_checker (.*);
